// File: hw/rtl/cud_pkg.sv
// Shared types, constants and the binomial table function for the card dealer.
package cud_pkg;

	localparam int RANK_W  = 40;
	localparam int CARD_W  = 6;
	localparam int BINOM_W = RANK_W + 1;
	localparam int MAX_K   = 16;

	localparam logic [BINOM_W-1:0] BINOM_SAT = BINOM_W'(1) << RANK_W;

	localparam logic CMD_RESTORE = 1'b0;
	localparam logic CMD_DEAL    = 1'b1;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CHECK,
		ST_SELECT,
		ST_PACK
	} cud_state_t;

	// C(n,k) clipped at 2^40, built by Pascal rows; evaluated at elaboration
	function automatic logic [BINOM_W-1:0] binom_sat(input int n, input int k);
		logic [BINOM_W-1:0] row [0:MAX_K];
		logic [BINOM_W:0]   s;
		for (int j = 0; j <= MAX_K; j++) begin
			row[j] = (j == 0) ? BINOM_W'(1) : '0;
		end
		for (int i = 1; i <= n; i++) begin
			for (int j = MAX_K; j >= 1; j--) begin
				s = {1'b0, row[j]} + {1'b0, row[j-1]};
				row[j] = (s > {1'b0, BINOM_SAT}) ? BINOM_SAT : s[BINOM_W-1:0];
			end
		end
		if (k < 0 || k > MAX_K) begin
			return '0;
		end
		return row[k];
	endfunction

endpackage

// File: hw/rtl/cud_ram.sv
// Generic simple dual-port RAM with registered read.
module cud_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 52
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/combination_unrank_deal_core.sv
// Combination unranking card dealer: the deck lives in a RAM, walked once to select and once to pack.
// A restore (command 0) rewrites the deck RAM one entry a cycle, keeping busy high while it runs;
// the same pass runs after reset before the first start is taken. A deal (command 1) first checks
// the rank in a check state, then walks the deck RAM one entry a cycle up to the last card chosen
// (at most the remaining count), issuing at most one card a cycle on valid, then packs the deck in
// another walk of the remaining count, holding busy until the pack is done. A rank at or above
// C(remaining, HAND) gives a single beat with error and last set and ends the deal there. Results
// come out on valid for one cycle each and cannot be held off.
module combination_unrank_deal_core
	import cud_pkg::*;
#(
	parameter int DECK = 52,
	parameter int HAND = 13
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [RANK_W-1:0] rank,
	output logic              valid,
	output logic [CARD_W-1:0] card,
	output logic              last,
	output logic              error
);

	localparam int AW = $clog2(DECK);
	localparam int NW = $clog2(DECK + 1);
	localparam int KW = $clog2(HAND + 1);

	// binomial table, registered read
	logic [BINOM_W-1:0] binom_tab [DECK+1][HAND+1];
	for (genvar gn = 0; gn <= DECK; gn++) begin : g_row
		for (genvar gk = 0; gk <= HAND; gk++) begin : g_col
			localparam logic [BINOM_W-1:0] V = binom_sat(gn, gk);
			assign binom_tab[gn][gk] = V;
		end
	end

	cud_state_t state_q, state_d;

	logic [NW-1:0]      cnt_q;
	logic [NW-1:0]      left_q;
	logic [NW-1:0]      wp_q;
	logic [KW-1:0]      need_q;
	logic [AW-1:0]      ptr_q;
	logic [RANK_W-1:0]  r_q;
	logic [AW-1:0]      pick_q [HAND];
	logic [BINOM_W-1:0] rom_q;

	logic               valid_q, last_q, error_q;
	logic [CARD_W-1:0]  card_q;

	logic [NW-1:0]      rom_n;
	logic [KW-1:0]      rom_k;
	logic               re, we;
	logic [AW-1:0]      raddr, waddr;
	logic [CARD_W-1:0]  wdata, rdata;
	logic               take, ptr_more, ptr_end, pack_wr;

	cud_ram #(.WIDTH(CARD_W), .DEPTH(DECK)) u_deck (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign take     = (NW'(need_q) >= left_q) || ({1'b0, r_q} < rom_q);
	assign ptr_more = (NW'(ptr_q) + NW'(1)) < cnt_q;
	assign ptr_end  = (NW'(ptr_q) + NW'(1)) == cnt_q;
	// picks are kept in deck order; the head is the next one to drop
	assign pack_wr  = (ptr_q != pick_q[0]);

	always_ff @(posedge clk) begin
		rom_q <= binom_tab[rom_n][rom_k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		re      = 1'b0;
		raddr   = '0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = '0;
		rom_n   = cnt_q;
		rom_k   = KW'(HAND);
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = CARD_W'(ptr_q);
				if (ptr_q == AW'(DECK - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = (command == CMD_DEAL) ? ST_CHECK : ST_INIT;
				end
			end
			ST_CHECK: begin
				rom_n = cnt_q - NW'(1);
				rom_k = KW'(HAND - 1);
				re    = 1'b1;
				raddr = '0;
				if ({1'b0, r_q} >= rom_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SELECT;
				end
			end
			ST_SELECT: begin
				rom_n = (left_q >= NW'(2)) ? left_q - NW'(2) : '0;
				rom_k = (need_q > KW'(take)) ? need_q - KW'(1) - KW'(take) : '0;
				if (take && need_q == KW'(1)) begin
					state_d = ST_PACK;
					re      = 1'b1;
					raddr   = '0;
				end else begin
					re    = ptr_more;
					raddr = ptr_q + AW'(1);
				end
			end
			ST_PACK: begin
				we    = pack_wr;
				waddr = AW'(wp_q);
				wdata = rdata;
				re    = ptr_more;
				raddr = ptr_q + AW'(1);
				if (ptr_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			cnt_q    <= NW'(DECK);
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == AW'(DECK - 1)) begin
						ptr_q <= '0;
						cnt_q <= NW'(DECK);
					end
				end
				ST_IDLE: begin
					ptr_q <= '0;
				end
				ST_CHECK: begin
					ptr_q    <= '0;
					if ({1'b0, r_q} >= rom_q) begin
						valid_q <= 1'b1;
					end
				end
				ST_SELECT: begin
					valid_q         <= take;
					if (take && need_q == KW'(1)) begin
						ptr_q <= '0;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_PACK: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_end) begin
						ptr_q <= '0;
						cnt_q <= wp_q + NW'(pack_wr);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				r_q <= rank;
			end
			ST_CHECK: begin
				left_q  <= cnt_q;
				need_q  <= KW'(HAND);
				card_q  <= '0;
				last_q  <= 1'b1;
				error_q <= 1'b1;
				wp_q    <= '0;
			end
			ST_SELECT: begin
				left_q  <= left_q - NW'(1);
				need_q  <= need_q - KW'(take);
				card_q  <= rdata;
				last_q  <= (need_q == KW'(1));
				error_q <= 1'b0;
				if (!take) begin
					r_q <= r_q - rom_q[RANK_W-1:0];
				end
				if (take) begin
					for (int j = 0; j < HAND - 1; j++) begin
						pick_q[j] <= pick_q[j+1];
					end
					pick_q[HAND-1] <= ptr_q;
				end
			end
			ST_PACK: begin
				wp_q <= wp_q + NW'(pack_wr);
				if (!pack_wr) begin
					for (int j = 0; j < HAND - 1; j++) begin
						pick_q[j] <= pick_q[j+1];
					end
				end
			end
			default: ;
		endcase
	end

	assign busy  = (state_q != ST_IDLE);
	assign valid = valid_q;
	assign card  = card_q;
	assign last  = last_q;
	assign error = error_q;

endmodule

// File: hw/rtl/cud_checker.sv
// Port-level checks on the card dealer's start handshake and result beats, bound to the top level.
module cud_checker
	import cud_pkg::*;
#(
	parameter int DECK = 52
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              valid,
	input logic [CARD_W-1:0] card,
	input logic              last,
	input logic              error
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_beat_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result beat without work in progress");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		valid && error |-> last && card == '0)
		else $error("error beat not a lone last beat with card zero");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("beat right after the last beat of a deal");

	a_card_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !error |-> {1'b0, card} < (CARD_W + 1)'(DECK))
		else $error("card value outside the deck");

endmodule

bind combination_unrank_deal_core cud_checker #(.DECK(DECK)) u_cud_checker (.*);
